@@ hw/rtl/hmq_pkg.sv @@
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package hmq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CIDX_W   = IDX_W + 1;   // child index, may point past the array
	localparam int KEY_W    = 32;
	localparam int TAG_W    = 16;
	localparam int OCNT_W   = 7;           // entry_count port width

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

endpackage

@@ hw/rtl/hmq_ram.sv @@
// ----------------------------------------------------------------------------
// hmq_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module hmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ hw/rtl/binary_max_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Array-based binary max-heap of key/tag entries held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload                                   dir
//  -------   --------------   ---------------------------------------   ---
//  command   start / busy     op, entry_key, entry_tag                  in
//  result    done (strobe)    top_key, top_tag, entry_count,            out
//                             queue_empty, status
//
//  A command word is taken at a clock edge with start high and busy low; one
//  result word follows per command, shown for the single cycle that done is
//  high. The receiver cannot stall. The heap walks one level per cycle: a push
//  climbs the sift-up levels and writes the entry where it stops, a pop reads
//  the last entry and then descends the sift-down levels; errors and a pop
//  that empties the heap finish without a walk. The single RAM write port and
//  its registered reads set this pace. After reset the heap is empty; storage
//  needs no clearing since only entries below the count are ever used.
//
// ----------------------------------------------------------------------------
module binary_max_heap_queue
	import hmq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [KEY_W-1:0]  entry_key,
	input  logic [TAG_W-1:0]  entry_tag,
	output logic              done,
	output logic [KEY_W-1:0]  top_key,
	output logic [TAG_W-1:0]  top_tag,
	output logic [OCNT_W-1:0] entry_count,
	output logic              queue_empty,
	output logic [1:0]        status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,     // compare moving entry against its parent
		S_FIN,    // write the moving entry at its final slot
		S_LOAD,   // capture the last entry, fetch root's children
		S_DOWN    // compare moving entry against its children
	} state_t;

	state_t           state_q;
	entry_t           cur_q;      // entry being sifted, kept out of the RAM
	entry_t           root_q;     // copy of slot 0 for the result port
	logic [IDX_W-1:0] pos_q;      // slot the moving entry currently owns
	logic [CNT_W-1:0] count_q;
	status_t          status_q;
	logic             done_q;

	// RAM ports
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic [IDX_W-1:0] raddr_a;
	logic [IDX_W-1:0] raddr_b;
	entry_t           rdata_a;
	entry_t           rdata_b;

	hmq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	logic              accept;
	logic              full;
	logic [IDX_W-1:0]  push_slot;
	logic [IDX_W-1:0]  push_parent;
	logic [IDX_W-1:0]  last_slot;
	logic [IDX_W-1:0]  up_parent;    // parent of the slot read in S_UP
	logic [IDX_W-1:0]  par_slot;     // slot that rdata_a came from in S_UP
	logic              up_swap;
	logic [CIDX_W-1:0] left_idx;
	logic [CIDX_W-1:0] right_idx;
	logic              left_ok;
	logic              right_ok;
	logic              take_left;
	logic              take_right;
	logic              down_move;
	logic [IDX_W-1:0]  best_slot;
	entry_t            best_ent;
	logic [CIDX_W-1:0] next_left;
	logic [CIDX_W-1:0] next_right;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q >= CNT_W'(CAPACITY));

	assign push_slot   = count_q[IDX_W-1:0];
	assign push_parent = (push_slot - IDX_W'(1)) >> 1;
	assign last_slot   = IDX_W'(count_q - CNT_W'(1));

	// Sift-up compare: rdata_a holds the parent of pos_q.
	assign par_slot  = (pos_q - IDX_W'(1)) >> 1;
	assign up_parent = (par_slot - IDX_W'(1)) >> 1;
	assign up_swap   = (rdata_a.key < cur_q.key);

	// Sift-down compare: rdata_a/rdata_b hold the children of pos_q.
	// Left child is tested first; right wins only when strictly larger.
	assign left_idx   = {pos_q, 1'b0} + CIDX_W'(1);
	assign right_idx  = {pos_q, 1'b0} + CIDX_W'(2);
	assign left_ok    = (left_idx < CIDX_W'(count_q));
	assign right_ok   = (right_idx < CIDX_W'(count_q));
	assign take_left  = left_ok && (rdata_a.key > cur_q.key);
	assign take_right = right_ok &&
		(rdata_b.key > (take_left ? rdata_a.key : cur_q.key));
	assign down_move  = take_left || take_right;
	assign best_slot  = take_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
	assign best_ent   = take_right ? rdata_b : rdata_a;
	assign next_left  = {best_slot, 1'b0} + CIDX_W'(1);
	assign next_right = {best_slot, 1'b0} + CIDX_W'(2);

	// RAM address and write selection. A write never hits a slot whose read data
	// is used: sift-up reads above the written slot, sift-down reads below it,
	// so no forwarding is needed.
	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = cur_q;
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				raddr_a = (op == OP_PUSH) ? push_parent : last_slot;
			end
			S_UP: begin
				we      = 1'b1;
				wdata   = up_swap ? rdata_a : cur_q;
				raddr_a = up_parent;
			end
			S_FIN: begin
				we = 1'b1;
			end
			S_LOAD: begin
				raddr_a = IDX_W'(1);
				raddr_b = IDX_W'(2);
			end
			S_DOWN: begin
				we      = 1'b1;
				wdata   = down_move ? best_ent : cur_q;
				raddr_a = next_left[IDX_W-1:0];
				raddr_b = next_right[IDX_W-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= ST_OK;
			done_q   <= 1'b0;
			pos_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						if (op == OP_PUSH) begin
							if (full) begin
								// drop the word, report and hold state
								status_q <= ST_PUSH_FULL;
								done_q   <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
								pos_q   <= push_slot;
								state_q <= (push_slot == '0) ? S_FIN : S_UP;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= ST_POP_EMPTY;
								done_q   <= 1'b1;
							end else begin
								count_q <= count_q - CNT_W'(1);
								if (count_q == CNT_W'(1)) begin
									done_q <= 1'b1;  // heap just emptied
								end else begin
									state_q <= S_LOAD;
								end
							end
						end
					end
				end
				S_UP: begin
					if (up_swap) begin
						// parent moves down, keep climbing
						pos_q <= par_slot;
						if (par_slot == '0) begin
							state_q <= S_FIN;
						end
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_LOAD: begin
					pos_q   <= '0;
					state_q <= S_DOWN;
				end
				S_DOWN: begin
					if (down_move) begin
						pos_q <= best_slot;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: moving entry and root shadow.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= '{key: entry_key, tag: entry_tag};
		end else if (state_q == S_LOAD) begin
			cur_q <= rdata_a;    // last entry, now headed for the root
		end
		if (we && (waddr == '0)) begin
			root_q <= wdata;
		end
	end

	assign done        = done_q;
	assign queue_empty = (count_q == '0);
	assign top_key     = queue_empty ? '0 : root_q.key;
	assign top_tag     = queue_empty ? '0 : root_q.tag;
	assign entry_count = OCNT_W'(count_q);
	assign status      = status_q;

endmodule
